FILE: rtl/acpu_pkg.sv
// Shared types, codes and constants for the accumulator CPU core.
package acpu_pkg;

    localparam int MEMORY_ADDRESS_BITS_DEFAULT = 16;

    localparam int FLAG_Z = 0;
    localparam int FLAG_V = 1;
    localparam int FLAG_E = 2;

    typedef enum logic [1:0] {
        COND_ALWAYS = 2'd0,
        COND_ZERO   = 2'd1,
        COND_OVF    = 2'd2,
        COND_ERR    = 2'd3
    } cond_t;

    typedef enum logic [1:0] {
        OPC_MOVE  = 2'd0,
        OPC_ALU   = 2'd1,
        OPC_LD_LO = 2'd2,
        OPC_LD_HI = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        LOC_X       = 3'd0,
        LOC_Y       = 3'd1,
        LOC_PC_LO   = 3'd2,
        LOC_PC_HI   = 3'd3,
        LOC_DA_LO   = 3'd4,
        LOC_DA_HI   = 3'd5,
        LOC_MEM     = 3'd6,
        LOC_PORT    = 3'd7
    } location_t;

    typedef enum logic [3:0] {
        ALU_CLR_ALL  = 4'h0,
        ALU_CLR_ZV   = 4'h1,
        ALU_CLR_ERR  = 4'h2,
        ALU_SET_ERR  = 4'h3,
        ALU_ADD      = 4'h4,
        ALU_ADD_INC  = 4'h5,
        ALU_SUB      = 4'h6,
        ALU_SUB_DEC  = 4'h7,
        ALU_OR       = 4'h8,
        ALU_XOR      = 4'h9,
        ALU_AND      = 4'hA,
        ALU_NAND     = 4'hB,
        ALU_SHR      = 4'hC,
        ALU_SHR_ONE  = 4'hD,
        ALU_SHL      = 4'hE,
        ALU_SHL_ONE  = 4'hF
    } alu_op_t;

    typedef struct packed {
        logic [7:0] instruction;
        logic [7:0] port_read_data;
    } in_word_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [7:0]  acc_value;
        logic        zero_flag;
        logic        overflow_flag;
        logic        error_flag;
        logic        executed;
        logic        port_write;
        logic        port_read;
        logic [15:0] port_address;
        logic [7:0]  port_data;
    } out_word_t;

    // Architectural registers outside the data memory.
    typedef struct packed {
        logic [7:0]  acc;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [15:0] pc;
        logic [15:0] da;
        logic [2:0]  flags;
    } cpu_state_t;

endpackage

FILE: rtl/acpu_exec.sv
// Combinational execute logic: one instruction against the current state.
module acpu_exec (
    input  acpu_pkg::cpu_state_t state,
    input  acpu_pkg::in_word_t   in_word,
    input  logic [7:0]           mem_rdata,
    output acpu_pkg::cpu_state_t state_next,
    output logic                 mem_we,
    output logic [7:0]           mem_wdata,
    output acpu_pkg::out_word_t  result
);
    import acpu_pkg::*;

    cond_t      cond;
    opcode_t    opc;
    location_t  loc;
    logic [3:0] opd;
    logic       run;
    logic [8:0] sum9;
    logic [8:0] diff9;
    logic [7:0] alu_res;
    logic       alu_v;
    logic       alu_writes;

    assign cond = cond_t'(in_word.instruction[7:6]);
    assign opc  = opcode_t'(in_word.instruction[5:4]);
    assign opd  = in_word.instruction[3:0];
    assign loc  = location_t'(opd[2:0]);

    always_comb
    begin
        case (cond)
            COND_ALWAYS: run = 1'b1;
            COND_ZERO:   run = state.flags[FLAG_Z];
            COND_OVF:    run = state.flags[FLAG_V];
            COND_ERR:    run = state.flags[FLAG_E];
            default:     run = 1'b1;
        endcase
    end

    // Bit 8 of the 9-bit sum is the carry; of the difference, the borrow.
    assign sum9  = {1'b0, state.x} + {1'b0, state.y} + {8'd0, opd[0]};
    assign diff9 = {1'b0, state.x} - {1'b0, state.y} - {8'd0, opd[0]};

    always_comb
    begin
        alu_res    = 8'd0;
        alu_v      = state.flags[FLAG_V];
        alu_writes = 1'b1;
        case (alu_op_t'(opd))
            ALU_CLR_ALL, ALU_CLR_ZV, ALU_CLR_ERR, ALU_SET_ERR:
                alu_writes = 1'b0;
            ALU_ADD, ALU_ADD_INC:
            begin
                alu_res = sum9[7:0];
                alu_v   = sum9[8];
            end
            ALU_SUB, ALU_SUB_DEC:
            begin
                alu_res = diff9[7:0];
                alu_v   = diff9[8];
            end
            ALU_OR:   alu_res = state.x | state.y;
            ALU_XOR:  alu_res = state.x ^ state.y;
            ALU_AND:  alu_res = state.x & state.y;
            ALU_NAND: alu_res = ~(state.x & state.y);
            ALU_SHR, ALU_SHR_ONE:
            begin
                alu_res = {opd[0], state.x[7:1]};
                alu_v   = state.x[0];
            end
            ALU_SHL, ALU_SHL_ONE:
            begin
                alu_res = {state.x[6:0], opd[0]};
                alu_v   = state.x[7];
            end
            default: alu_writes = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next    = state;
        state_next.pc = state.pc + 16'd1;
        mem_we        = 1'b0;
        mem_wdata     = state.acc;
        result        = '0;

        if (run)
        begin
            case (opc)
                OPC_MOVE:
                begin
                    if (opd[3])
                    begin
                        case (loc)
                            LOC_X:     state_next.acc = state.x;
                            LOC_Y:     state_next.acc = state.y;
                            LOC_PC_LO: state_next.acc = state.pc[7:0];
                            LOC_PC_HI: state_next.acc = state.pc[15:8];
                            LOC_DA_LO: state_next.acc = state.da[7:0];
                            LOC_DA_HI: state_next.acc = state.da[15:8];
                            LOC_MEM:   state_next.acc = mem_rdata;
                            LOC_PORT:
                            begin
                                state_next.acc      = in_word.port_read_data;
                                result.port_read    = 1'b1;
                                result.port_address = state.da;
                            end
                            default:   state_next.acc = state.acc;
                        endcase
                    end
                    else
                    begin
                        case (loc)
                            LOC_X:     state_next.x = state.acc;
                            LOC_Y:     state_next.y = state.acc;
                            LOC_PC_LO: state_next.pc = {state.pc[15:8], state.acc};
                            LOC_PC_HI: state_next.pc = {state.acc, state.pc[7:0]};
                            LOC_DA_LO: state_next.da = {state.da[15:8], state.acc};
                            LOC_DA_HI: state_next.da = {state.acc, state.da[7:0]};
                            LOC_MEM:   mem_we = 1'b1;
                            LOC_PORT:
                            begin
                                result.port_write   = 1'b1;
                                result.port_address = state.da;
                                result.port_data    = state.acc;
                            end
                            default:   mem_we = 1'b0;
                        endcase
                    end
                end
                OPC_ALU:
                begin
                    case (alu_op_t'(opd))
                        ALU_CLR_ALL: state_next.flags = 3'b000;
                        ALU_CLR_ZV:  state_next.flags = {state.flags[FLAG_E], 2'b00};
                        ALU_CLR_ERR: state_next.flags[FLAG_E] = 1'b0;
                        ALU_SET_ERR: state_next.flags[FLAG_E] = 1'b1;
                        default:     state_next.flags = state.flags;
                    endcase
                    if (alu_writes)
                    begin
                        state_next.acc          = alu_res;
                        state_next.flags[FLAG_V] = alu_v;
                        state_next.flags[FLAG_Z] = (alu_res == 8'd0);
                    end
                end
                OPC_LD_LO: state_next.acc = {state.acc[7:4], opd};
                OPC_LD_HI: state_next.acc = {opd, state.acc[3:0]};
                default:   state_next.acc = state.acc;
            endcase
        end

        result.next_pc       = state_next.pc;
        result.acc_value     = state_next.acc;
        result.zero_flag     = state_next.flags[FLAG_Z];
        result.overflow_flag = state_next.flags[FLAG_V];
        result.error_flag    = state_next.flags[FLAG_E];
        result.executed      = run;
    end

endmodule

FILE: rtl/accumulator_cpu_core_8bit_core.sv
// An accepted word is registered at the input, executed, and its result word registered at the output.
// Throughput: one instruction per cycle; the execute stage holds only under output stall.
// The data memory read is prefetched at the current data address, with write bypass.
// Reset clears the control and architectural registers, then a clearing pass writes zero
// to every memory byte, with in_ready held low throughout.
module accumulator_cpu_core_8bit_core #(
    parameter int MEMORY_ADDRESS_BITS = acpu_pkg::MEMORY_ADDRESS_BITS_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  acpu_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output acpu_pkg::out_word_t out_data
);
    import acpu_pkg::*;

    localparam int MEM_DEPTH = 1 << MEMORY_ADDRESS_BITS;

    logic [7:0] mem [MEM_DEPTH];

    logic                           in_valid_reg;
    in_word_t                       in_word_reg;
    cpu_state_t                     state_reg;
    cpu_state_t                     state_next;
    logic                           out_valid_reg;
    out_word_t                      out_word_reg;
    out_word_t                      result;
    logic                           clearing_reg;
    logic [MEMORY_ADDRESS_BITS-1:0] clr_cnt_reg;
    logic [7:0]                     mem_q_reg;
    logic                           byp_reg;
    logic [7:0]                     byp_data_reg;
    logic                           exec_fire;
    logic                           mem_we;
    logic [7:0]                     mem_wdata;
    logic [7:0]                     mem_rdata;
    logic [MEMORY_ADDRESS_BITS-1:0] rd_addr;
    logic [MEMORY_ADDRESS_BITS-1:0] wr_addr;
    logic                           wr_en;
    logic [7:0]                     wr_data;

    acpu_exec u_exec (
        .state      (state_reg),
        .in_word    (in_word_reg),
        .mem_rdata  (mem_rdata),
        .state_next (state_next),
        .mem_we     (mem_we),
        .mem_wdata  (mem_wdata),
        .result     (result)
    );

    assign exec_fire = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !clearing_reg && (!in_valid_reg || exec_fire);
    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            byp_reg       <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            else if (exec_fire)
                in_valid_reg <= 1'b0;

            if (exec_fire)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (exec_fire)
                state_reg <= state_next;

            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + MEMORY_ADDRESS_BITS'(1);
                if (&clr_cnt_reg)
                    clearing_reg <= 1'b0;
            end

            byp_reg <= exec_fire && mem_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_word_reg <= in_data;
        if (exec_fire)
            out_word_reg <= result;
        byp_data_reg <= mem_wdata;
    end

    // The read port always tracks the data address the next instruction will see.
    // A store lands in the same cycle it is read back, so the stored byte is bypassed.
    assign rd_addr   = exec_fire ? state_next.da[MEMORY_ADDRESS_BITS-1:0]
                                 : state_reg.da[MEMORY_ADDRESS_BITS-1:0];
    assign mem_rdata = byp_reg ? byp_data_reg : mem_q_reg;

    assign wr_en   = clearing_reg || (exec_fire && mem_we);
    assign wr_addr = clearing_reg ? clr_cnt_reg : state_reg.da[MEMORY_ADDRESS_BITS-1:0];
    assign wr_data = clearing_reg ? 8'd0 : mem_wdata;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg <= mem[rd_addr];
    end

endmodule

FILE: rtl/acpu_checker.sv
// Port-level assertions for the accumulator CPU core, bound to the top level.
module acpu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input acpu_pkg::out_word_t out_data
);
    import acpu_pkg::*;

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result word changed while stalled");

    // A skipped instruction touches no port.
    a_skip_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.executed |->
            !out_data.port_write && !out_data.port_read &&
            out_data.port_address == 16'd0 && out_data.port_data == 8'd0)
        else $error("skipped instruction shows port activity");

    // One instruction cannot both read and write the port.
    a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.port_write && out_data.port_read))
        else $error("port read and write in one word");

    // Port address and data are zero unless the port is accessed.
    a_port_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.port_write && !out_data.port_read |->
            out_data.port_address == 16'd0 && out_data.port_data == 8'd0)
        else $error("port fields set without a port access");

    // Data to the port appears only on a write.
    a_port_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.port_read |-> out_data.port_data == 8'd0)
        else $error("port data set on a port read");

endmodule

bind accumulator_cpu_core_8bit_core acpu_checker u_acpu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
